[hdl/xbt_pkg.sv]
`default_nettype none
// ============================================================================
// xbt_pkg: shared types and constants of the XML byte tokenizer
// Token codes, string modes, the payload structs of both channels and the
// command format that links the classifier to the token serializer.
// ============================================================================
package xbt_pkg;

  // Depth of the command queue between classifier and serializer.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  typedef enum logic [3:0] {
    TK_SEP   = 4'd0,
    TK_LT    = 4'd1,
    TK_GT    = 4'd2,
    TK_EQ    = 4'd3,
    TK_SLASH = 4'd4,
    TK_MINUS = 4'd5,
    TK_QUOTE = 4'd6,
    TK_SBYTE = 4'd7,
    TK_SEND  = 4'd8
  } token_kind_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_NAME   = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_TEXT   = 2'd3
  } string_mode_e;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_document;
  } in_item_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] string_char;
    logic       last_of_run;
  } out_item_t;

  // One classified byte: one or two tokens. Of two tokens, one is always a string end.
  typedef struct packed {
    logic        two_tokens;
    token_kind_e kind0;
    token_kind_e kind1;
    logic [7:0]  char_byte;
  } cmd_t;

endpackage
`default_nettype wire

[hdl/xbt_front.sv]
`default_nettype none
// ============================================================================
// xbt_front: byte classifier
// Holds the lexer state and turns each accepted byte into a token command.
// ============================================================================
module xbt_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire xbt_pkg::in_item_t item_i,
  output logic                  cmd_valid_o,
  output xbt_pkg::cmd_t         cmd_o
);

  typedef struct packed {
    logic                  emit;
    xbt_pkg::token_kind_e  kind;
    xbt_pkg::string_mode_e mode;
    logic                  tag_set;
    logic                  tag_clr;
  } plain_t;

  logic                  tag_q, tag_d;
  logic                  sep_q, sep_d;
  xbt_pkg::string_mode_e mode_q, mode_d;

  logic [1:0]           n;
  xbt_pkg::token_kind_e k0, k1, k_last;
  plain_t               p;
  logic [7:0]           ch;
  logic                 name_delim;

  // Handling of a byte while no string is open.
  function automatic plain_t plain_fn(logic [7:0] c, logic in_tag, logic last_sep);
    plain_t r;
    r.emit    = 1'b1;
    r.kind    = xbt_pkg::TK_SBYTE;
    r.mode    = xbt_pkg::MODE_NONE;
    r.tag_set = 1'b0;
    r.tag_clr = 1'b0;
    case (c)
      xbt_pkg::ChSpace, xbt_pkg::ChTab: begin
        r.kind = xbt_pkg::TK_SEP;
        r.emit = !last_sep;
      end
      xbt_pkg::ChLt: begin
        r.kind    = xbt_pkg::TK_LT;
        r.tag_set = 1'b1;
      end
      xbt_pkg::ChGt: begin
        r.kind    = xbt_pkg::TK_GT;
        r.tag_clr = 1'b1;
      end
      xbt_pkg::ChEq:    r.kind = xbt_pkg::TK_EQ;
      xbt_pkg::ChSlash: r.kind = xbt_pkg::TK_SLASH;
      xbt_pkg::ChMinus: r.kind = xbt_pkg::TK_MINUS;
      xbt_pkg::ChCr, xbt_pkg::ChLf: r.emit = 1'b0;
      xbt_pkg::ChQuote: begin
        if (in_tag) begin
          r.kind = xbt_pkg::TK_QUOTE;
          r.mode = xbt_pkg::MODE_QUOTED;
        end else begin
          r.mode = xbt_pkg::MODE_TEXT;
        end
      end
      default: r.mode = in_tag ? xbt_pkg::MODE_NAME : xbt_pkg::MODE_TEXT;
    endcase
    return r;
  endfunction

  assign ch = item_i.data_byte;

  always_comb begin
    tag_d  = tag_q;
    mode_d = mode_q;
    n      = 2'd0;
    k0     = xbt_pkg::TK_SEP;
    k1     = xbt_pkg::TK_SEP;
    name_delim = (ch == xbt_pkg::ChEq) || (ch == xbt_pkg::ChSpace) ||
                 (ch == xbt_pkg::ChTab) || (ch == xbt_pkg::ChCr) ||
                 (ch == xbt_pkg::ChLf) || (ch == xbt_pkg::ChSlash) ||
                 (ch == xbt_pkg::ChGt);
    // A name delimiter is handled right after a string end, so no separator is pending.
    p = plain_fn(ch, tag_q, (mode_q == xbt_pkg::MODE_NONE) ? sep_q : 1'b0);

    case (mode_q)
      xbt_pkg::MODE_NAME: begin
        if (name_delim) begin
          k0     = xbt_pkg::TK_SEND;
          k1     = p.kind;
          n      = p.emit ? 2'd2 : 2'd1;
          mode_d = p.mode;
          if (p.tag_set) tag_d = 1'b1;
          if (p.tag_clr) tag_d = 1'b0;
        end else begin
          k0 = xbt_pkg::TK_SBYTE;
          n  = 2'd1;
        end
      end
      xbt_pkg::MODE_QUOTED: begin
        if (ch == xbt_pkg::ChQuote) begin
          k0     = xbt_pkg::TK_SEND;
          k1     = xbt_pkg::TK_QUOTE;
          n      = 2'd2;
          mode_d = xbt_pkg::MODE_NONE;
        end else begin
          k0 = xbt_pkg::TK_SBYTE;
          n  = 2'd1;
        end
      end
      xbt_pkg::MODE_TEXT: begin
        if (ch == xbt_pkg::ChLt) begin
          k0     = xbt_pkg::TK_SEND;
          k1     = xbt_pkg::TK_LT;
          n      = 2'd2;
          tag_d  = 1'b1;
          mode_d = xbt_pkg::MODE_NONE;
        end else begin
          k0 = xbt_pkg::TK_SBYTE;
          n  = 2'd1;
        end
      end
      default: begin
        k0     = p.kind;
        n      = p.emit ? 2'd1 : 2'd0;
        mode_d = p.mode;
        if (p.tag_set) tag_d = 1'b1;
        if (p.tag_clr) tag_d = 1'b0;
      end
    endcase

    k_last = (n == 2'd2) ? k1 : k0;
    sep_d  = (n == 2'd0) ? sep_q : (k_last == xbt_pkg::TK_SEP);

    if (item_i.end_of_document) begin
      // A string left open is closed; then the next byte starts a new document.
      if ((mode_d != xbt_pkg::MODE_NONE) && (n != 2'd2)) begin
        if (n == 2'd0) begin
          k0 = xbt_pkg::TK_SEND;
        end else begin
          k1 = xbt_pkg::TK_SEND;
        end
        n = n + 2'd1;
      end
      tag_d  = 1'b0;
      mode_d = xbt_pkg::MODE_NONE;
      sep_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= 1'b0;
      sep_q  <= 1'b0;
      mode_q <= xbt_pkg::MODE_NONE;
    end else if (accept_i) begin
      tag_q  <= tag_d;
      sep_q  <= sep_d;
      mode_q <= mode_d;
    end
  end

  assign cmd_valid_o      = accept_i && (n != 2'd0);
  assign cmd_o.two_tokens = (n == 2'd2);
  assign cmd_o.kind0      = k0;
  assign cmd_o.kind1      = k1;
  assign cmd_o.char_byte  = ch;

  a_eod_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.end_of_document |=>
      (mode_q == xbt_pkg::MODE_NONE) && !tag_q && !sep_q)
    else $error("state not cleared after end of document");

endmodule
`default_nettype wire

[hdl/xbt_queue.sv]
`default_nettype none
// ============================================================================
// xbt_queue: command queue
// Short first-in first-out buffer of token commands between the two halves.
// ============================================================================
module xbt_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          enq_i,
  input  wire xbt_pkg::cmd_t enq_data_i,
  input  wire logic          deq_i,
  output xbt_pkg::cmd_t      head_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned Aw = xbt_pkg::QueueAw;

  xbt_pkg::cmd_t     mem_q [xbt_pkg::QueueDepth];
  logic [Aw-1:0]     wptr_q, rptr_q;
  logic [Aw:0]       count_q;
  logic              do_enq, do_deq;

  assign full_o  = (count_q == (Aw+1)'(xbt_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_enq  = enq_i && !full_o;
  assign do_deq  = deq_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      mem_q[wptr_q] <= enq_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_enq) wptr_q <= wptr_q + 1'b1;
      if (do_deq) rptr_q <= rptr_q + 1'b1;
      if (do_enq && !do_deq) begin
        count_q <= count_q + 1'b1;
      end else if (do_deq && !do_enq) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (Aw+1)'(xbt_pkg::QueueDepth))
    else $error("command queue count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wptr_q == (rptr_q + count_q[Aw-1:0])))
    else $error("command queue pointers disagree with count");

endmodule
`default_nettype wire

[hdl/xbt_back.sv]
`default_nettype none
// ============================================================================
// xbt_back: token serializer
// Presents the tokens of the queue head one at a time and marks the last.
// ============================================================================
module xbt_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire xbt_pkg::cmd_t head_i,
  input  wire logic          head_empty_i,
  input  wire logic          pop_i,
  output logic               deq_o,
  output xbt_pkg::out_item_t result_o
);

  logic                 second_q;
  logic                 take;
  logic                 last;
  xbt_pkg::token_kind_e kind;

  assign kind  = second_q ? head_i.kind1 : head_i.kind0;
  assign last  = second_q || !head_i.two_tokens;
  assign take  = pop_i && !head_empty_i;
  assign deq_o = take && last;

  assign result_o.token_kind  = kind;
  assign result_o.string_char = (kind == xbt_pkg::TK_SBYTE) ? head_i.char_byte : 8'd0;
  assign result_o.last_of_run = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else if (take) begin
      second_q <= !last;
    end
  end

  a_second_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> !head_empty_i && head_i.two_tokens)
    else $error("second token pending without a two-token command");

endmodule
`default_nettype wire

[hdl/xml_byte_tokenizer_top.sv]
`default_nettype none
// ============================================================================
// xml_byte_tokenizer_top: streaming XML byte tokenizer
// Accepts one document byte per transaction and delivers token events.
// ============================================================================
// Each accepted document byte yields zero, one or two token transactions
// (separator, angle brackets, equals, slash, minus, quote, string byte,
// string end); the last token of a byte carries last_of_run. A byte is
// accepted in every cycle while the four-entry command queue between the
// classifier and the serializer has room, so the input rate is one byte
// per clock. The output side delivers one token per clock while pop is
// high and the queue is not empty, so bytes that produce two tokens (a
// string end followed by a delimiter, quote or open angle, or with
// end_of_document a token followed by a string end) are sent one token at
// a time and the queue absorbs them; sustained throughput is one byte per
// cycle whenever the byte stream averages at most one token per byte and
// pop is held. Raising end_of_document with a byte closes any open string
// and resets the lexer state, so the following byte begins a new document.
// ============================================================================
module xml_byte_tokenizer_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire xbt_pkg::in_item_t  item_i,
  output logic                    empty,
  input  wire logic               pop,
  output xbt_pkg::out_item_t      result_o
);

  logic          accept;
  logic          cmd_valid;
  xbt_pkg::cmd_t cmd;
  xbt_pkg::cmd_t head;
  logic          deq;

  // The queue's full flag gates every byte, also those that yield no token.
  assign accept = push && !full;

  xbt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  xbt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enq_i      (cmd_valid),
    .enq_data_i (cmd),
    .deq_i      (deq),
    .head_o     (head),
    .full_o     (full),
    .empty_o    (empty)
  );

  xbt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (empty),
    .pop_i        (pop),
    .deq_o        (deq),
    .result_o     (result_o)
  );

endmodule
`default_nettype wire
